### hw/rtl/color_ramp_gradient_map_defines.svh
// Assertion macros for the color ramp block.
`ifndef COLOR_RAMP_GRADIENT_MAP_DEFINES_SVH
`define COLOR_RAMP_GRADIENT_MAP_DEFINES_SVH
`ifndef SYNTHESIS
`define CRGM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define CRGM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CRGM_ASSERT_NOW(lbl, ante, cons, msg)
`define CRGM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/crgm_pkg.sv
// Shared constants and types of the color ramp block.
package crgm_pkg;
   localparam int MAX_STOPS_DEF    = 6;
   localparam int CHANNEL_BITS_DEF = 10;
   localparam int SAMPLE_W         = 16;
   localparam int POS_W            = 13;
   localparam int T_FRAC           = 12;
   localparam int T_W              = 13;
   localparam logic [T_W-1:0] T_ONE = 13'd4096;
   localparam int NUM_W            = 16;
   localparam int COUNT_W          = 3;
   localparam logic [31:0] RANGE_RESET = 32'h1000_0000;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd3;

   // register map indexes
   localparam int REG_RANGE     = 0;
   localparam int REG_COUNT     = 1;
   localparam int REG_STOP_BASE = 2;

   // default stops: position, then red, green, blue, alpha
   localparam int RESET_POS [3] = '{0, 2048, 4096};
   localparam int RESET_RED [3] = '{245, 460, 941};
   localparam int RESET_GRN [3] = '{286, 409, 951};
   localparam int RESET_BLU [3] = '{184, 327, 971};
   localparam int RESET_ALP = 1023;

   typedef struct packed {
      logic adv;
      logic vld;
   } pipe_ctl_type;
endpackage

### hw/rtl/crgm_stream_if.sv
// Valid/ready channel interfaces for sample beats and color beats.
interface crgm_req_if import crgm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_value;
   modport source (output valid, output sample_value, input ready);
   modport sink (input valid, input sample_value, output ready);
endinterface

interface crgm_rsp_if import crgm_pkg::*; #(parameter int CHANNEL_BITS = CHANNEL_BITS_DEF) ();
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red;
   logic [CHANNEL_BITS-1:0] green;
   logic [CHANNEL_BITS-1:0] blue;
   logic [CHANNEL_BITS-1:0] alpha;
   modport source (output valid, output red, output green, output blue, output alpha,
                   input ready);
   modport sink (input valid, input red, input green, input blue, input alpha,
                 output ready);
endinterface

### hw/rtl/crgm_div.sv
// Pipelined restoring divider, one quotient bit per stage, shared divisor across lanes.
module crgm_div
   import crgm_pkg::*;
#(
   parameter int LANES = 1,
   parameter int DEN_W = 16,
   parameter int Q_W   = 12,
   parameter int TAG_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pipe_ctl_type                 ctl_in,
   input  logic [DEN_W-1:0]             den_in,
   input  logic [LANES-1:0][DEN_W-1:0]  rem_in,
   input  logic [LANES-1:0][Q_W-1:0]    dvd_in,
   input  logic [TAG_W-1:0]             tag_in,
   output logic                         vld_out,
   output logic [LANES-1:0][Q_W-1:0]    q_out,
   output logic [TAG_W-1:0]             tag_out
);
   logic                        vld_ff [Q_W];
   logic [DEN_W-1:0]            den_ff [Q_W];
   logic [LANES-1:0][DEN_W-1:0] rem_ff [Q_W];
   logic [LANES-1:0][Q_W-1:0]   dvd_ff [Q_W];
   logic [TAG_W-1:0]            tag_ff [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic                        cur_vld;
      logic [DEN_W-1:0]            cur_den;
      logic [LANES-1:0][DEN_W-1:0] cur_rem;
      logic [LANES-1:0][Q_W-1:0]   cur_dvd;
      logic [TAG_W-1:0]            cur_tag;
      logic [LANES-1:0][DEN_W-1:0] rem_in_n;
      logic [LANES-1:0][Q_W-1:0]   dvd_in_n;

      if (k == 0) begin : g_first
         assign cur_vld = ctl_in.vld;
         assign cur_den = den_in;
         assign cur_rem = rem_in;
         assign cur_dvd = dvd_in;
         assign cur_tag = tag_in;
      end else begin : g_next
         assign cur_vld = vld_ff[k-1];
         assign cur_den = den_ff[k-1];
         assign cur_rem = rem_ff[k-1];
         assign cur_dvd = dvd_ff[k-1];
         assign cur_tag = tag_ff[k-1];
      end

      // shift in one dividend bit, subtract when it fits; quotient bits fill the
      // dividend register from the bottom
      always_comb begin
         logic [DEN_W:0] sh;
         logic           ge;
         for (int l = 0; l < LANES; l++) begin
            sh = {cur_rem[l], cur_dvd[l][Q_W-1]};
            ge = (sh >= {1'b0, cur_den});
            rem_in_n[l] = ge ? DEN_W'(sh - {1'b0, cur_den}) : sh[DEN_W-1:0];
            dvd_in_n[l] = {cur_dvd[l][Q_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (ctl_in.adv) begin
            vld_ff[k] <= cur_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl_in.adv) begin
            den_ff[k] <= cur_den;
            rem_ff[k] <= rem_in_n;
            dvd_ff[k] <= dvd_in_n;
            tag_ff[k] <= cur_tag;
         end
      end
   end

   assign vld_out = vld_ff[Q_W-1];
   assign q_out   = dvd_ff[Q_W-1];
   assign tag_out = tag_ff[Q_W-1];
endmodule

### hw/rtl/color_ramp_gradient_map.sv
// Top level of the color ramp: sample in, RGBA color out, APB register file.
//
//   channel   dir   handshake           payload
//   req_bus   in    valid/ready         sample_value (Q3.12 signed)
//   rsp_bus   out   valid/ready         red, green, blue, alpha
//   APB       in    psel/penable/pready 64-bit registers at 8*index
//
// One beat enters per clock while rsp_bus is not stalled; beats pass stage 0, the t divider,
// stages A to D, the blend divider and output stage E; both dividers resolve one bit per stage.
// Synchronous active-high reset clears valid bits and loads register defaults.
// A stall on rsp_bus freezes the whole pipeline and drops req_bus.ready in the
// same cycle; nothing in flight is lost or repeated.
`include "color_ramp_gradient_map_defines.svh"
module color_ramp_gradient_map
   import crgm_pkg::*;
#(
   parameter int MAX_STOPS    = MAX_STOPS_DEF,
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
   localparam int REG_N  = REG_STOP_BASE + MAX_STOPS,
   localparam int AW     = $clog2(8 * REG_N)
) (
   input  logic          clock,
   input  logic          reset,
   crgm_req_if.sink      req_bus,
   crgm_rsp_if.source    rsp_bus,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [AW-1:0] paddr,
   input  logic [63:0]   pwdata,
   output logic [63:0]   prdata,
   output logic          pready
);
   localparam int CB     = CHANNEL_BITS;
   localparam int STOP_W = 4 * CB + POS_W;
   localparam int IDX_W  = AW - 3;
   localparam int CNT_W  = $clog2(MAX_STOPS + 1);
   localparam int MAG_W  = CB + POS_W;          // |diff * dt| bound
   localparam int PRD_W  = CB + POS_W + 2;      // signed product / sum width
   localparam int TAG2_W = 2 + CB + 4 * CB + 4;
   localparam logic [CB-1:0] CH_MAX = {CB{1'b1}};

   // ---------------------------------------------------------------- registers
   logic [31:0]         range_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [STOP_W-1:0]   stop_ff [MAX_STOPS];
   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign wr_idx = paddr[AW-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= RANGE_RESET;
         count_ff <= COUNT_RESET;
         for (int i = 0; i < MAX_STOPS; i++) begin
            if (i < 3) begin
               stop_ff[i] <= {POS_W'(RESET_POS[i]), CB'(RESET_RED[i]), CB'(RESET_GRN[i]),
                              CB'(RESET_BLU[i]), CB'(RESET_ALP)};
            end else begin
               stop_ff[i] <= '0;
            end
         end
      end else if (wr_en) begin
         if (wr_idx == IDX_W'(REG_RANGE)) begin
            range_ff <= pwdata[31:0];
         end
         if (wr_idx == IDX_W'(REG_COUNT)) begin
            count_ff <= pwdata[COUNT_W-1:0];
         end
         for (int i = 0; i < MAX_STOPS; i++) begin
            if (wr_idx == IDX_W'(REG_STOP_BASE + i)) begin
               stop_ff[i] <= pwdata[STOP_W-1:0];
            end
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[AW-1:3] == IDX_W'(REG_RANGE)) begin
         prdata = {32'd0, range_ff};
      end
      if (paddr[AW-1:3] == IDX_W'(REG_COUNT)) begin
         prdata = 64'(count_ff);
      end
      for (int i = 0; i < MAX_STOPS; i++) begin
         if (paddr[AW-1:3] == IDX_W'(REG_STOP_BASE + i)) begin
            prdata = 64'(stop_ff[i]);
         end
      end
   end

   // ---------------------------------------------------------------- flow control
   // Whole pipeline moves together unless the output slot is full and stalled.
   logic         rsp_valid_ff;
   logic         adv;
   pipe_ctl_type ctl0;
   pipe_ctl_type ctl2;

   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // ---------------------------------------------------------------- stage 0: range
   // num = x - low, den = high - low, signs folded so den >= 0.
   logic                   v0_ff;
   logic [NUM_W-1:0]       num_ff;
   logic [NUM_W-1:0]       den_ff;
   logic [2:0]             flg_ff;    // {equal bounds, num <= 0, num >= den}
   logic signed [NUM_W:0]  num_raw, den_raw, num_abs, den_abs;

   always_comb begin
      num_raw = $signed({req_bus.sample_value[SAMPLE_W-1], req_bus.sample_value})
              - $signed({range_ff[15], range_ff[15:0]});
      den_raw = $signed({range_ff[31], range_ff[31:16]})
              - $signed({range_ff[15], range_ff[15:0]});
      num_abs = (den_raw < 0) ? -num_raw : num_raw;
      den_abs = (den_raw < 0) ? -den_raw : den_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= num_abs[NUM_W-1:0];
         den_ff <= den_abs[NUM_W-1:0];
         flg_ff <= {den_raw == 0, num_abs <= 0, num_abs >= den_abs};
      end
   end

   // ---------------------------------------------------------------- divider 1: t
   logic                    v1;
   logic [0:0][T_FRAC-1:0]  q1;
   logic [2:0]              flg1;

   assign ctl0 = '{adv: adv, vld: v0_ff};

   crgm_div #(
      .LANES (1),
      .DEN_W (NUM_W),
      .Q_W   (T_FRAC),
      .TAG_W (3)
   ) u_div_t (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (ctl0),
      .den_in  (den_ff),
      .rem_in  (num_ff),
      .dvd_in  ('0),
      .tag_in  (flg_ff),
      .vld_out (v1),
      .q_out   (q1),
      .tag_out (flg1)
   );

   // ---------------------------------------------------------------- stage A: clamp t
   logic           va_ff;
   logic [T_W-1:0] t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= v1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (flg1[2] || flg1[1]) begin
            t_ff <= '0;
         end else if (flg1[0]) begin
            t_ff <= T_ONE;
         end else begin
            t_ff <= {1'b0, q1[0]};
         end
      end
   end

   // ---------------------------------------------------------------- stage B: stop search
   logic              vb_ff;
   logic              grey_b_ff;
   logic              interp_b_ff;
   logic [T_W-1:0]    tb_ff;
   logic [STOP_W-1:0] sa_ff, sb_ff;
   logic [CNT_W-1:0]  n_sat;
   logic              sel_interp;
   logic [STOP_W-1:0] sel_a, sel_b, last_stop;

   always_comb begin
      n_sat = (32'(count_ff) > 32'(MAX_STOPS)) ? CNT_W'(MAX_STOPS) : CNT_W'(count_ff);
      last_stop = stop_ff[0];
      for (int i = 0; i < MAX_STOPS; i++) begin
         if (n_sat == CNT_W'(i + 1)) begin
            last_stop = stop_ff[i];
         end
      end
      sel_interp = 1'b0;
      sel_a      = stop_ff[0];
      sel_b      = stop_ff[0];
      if (t_ff > stop_ff[0][STOP_W-1 -: POS_W]) begin
         sel_a = last_stop;
         sel_b = last_stop;
         // walk downward so the lowest matching stop wins
         for (int i = MAX_STOPS - 1; i >= 1; i--) begin
            if ((CNT_W'(i) < n_sat) && (t_ff <= stop_ff[i][STOP_W-1 -: POS_W])) begin
               sel_a      = stop_ff[i-1];
               sel_b      = stop_ff[i];
               sel_interp = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (adv) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         grey_b_ff   <= (n_sat == '0);
         interp_b_ff <= sel_interp;
         tb_ff       <= t_ff;
         sa_ff       <= sel_a;
         sb_ff       <= sel_b;
      end
   end

   // ---------------------------------------------------------------- stage C: deltas
   logic                   vc_ff;
   logic                   grey_c_ff;
   logic                   use_div_c_ff;
   logic [CB-1:0]          grey_val_c_ff;
   logic [CB-1:0]          ca_c_ff   [4];
   logic signed [CB:0]     diff_c_ff [4];
   logic signed [POS_W:0]  dt_c_ff;
   logic [POS_W-1:0]       span_c_ff;
   logic signed [POS_W:0]  span_s, dt_s;
   logic [POS_W-1:0]       pa, pb;

   assign pa     = sa_ff[STOP_W-1 -: POS_W];
   assign pb     = sb_ff[STOP_W-1 -: POS_W];
   assign span_s = $signed({1'b0, pb}) - $signed({1'b0, pa});
   assign dt_s   = $signed({1'b0, tb_ff}) - $signed({1'b0, pa});

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (adv) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         grey_c_ff     <= grey_b_ff;
         use_div_c_ff  <= interp_b_ff && (span_s > 0);
         grey_val_c_ff <= (tb_ff > T_W'(CH_MAX)) ? CH_MAX : tb_ff[CB-1:0];
         dt_c_ff       <= dt_s;
         span_c_ff     <= span_s[POS_W-1:0];
         for (int c = 0; c < 4; c++) begin
            ca_c_ff[c]   <= sa_ff[(3-c)*CB +: CB];
            diff_c_ff[c] <= $signed({1'b0, sb_ff[(3-c)*CB +: CB]})
                          - $signed({1'b0, sa_ff[(3-c)*CB +: CB]});
         end
      end
   end

   // ---------------------------------------------------------------- stage D: products
   logic                   vd_ff;
   logic                   grey_d_ff;
   logic                   use_div_d_ff;
   logic [CB-1:0]          grey_val_d_ff;
   logic [POS_W-1:0]       span_d_ff;
   logic [CB-1:0]          ca_d_ff  [4];
   logic [3:0]             neg_d_ff;
   logic [3:0][MAG_W-1:0]  mag_d_ff;
   logic signed [PRD_W-1:0] prod [4];
   logic signed [PRD_W-1:0] prod_abs [4];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         prod[c]     = PRD_W'(diff_c_ff[c] * dt_c_ff);
         prod_abs[c] = (prod[c] < 0) ? -prod[c] : prod[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (adv) begin
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         grey_d_ff     <= grey_c_ff;
         use_div_d_ff  <= use_div_c_ff;
         grey_val_d_ff <= grey_val_c_ff;
         span_d_ff     <= span_c_ff;
         for (int c = 0; c < 4; c++) begin
            ca_d_ff[c]  <= ca_c_ff[c];
            neg_d_ff[c] <= prod[c] < 0;
            mag_d_ff[c] <= prod_abs[c][MAG_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------- divider 2: blend
   logic                   v2;
   logic [3:0][MAG_W-1:0]  q2;
   logic [TAG2_W-1:0]      tag2_in, tag2;

   assign ctl2    = '{adv: adv, vld: vd_ff};
   assign tag2_in = {grey_d_ff, use_div_d_ff, grey_val_d_ff,
                     ca_d_ff[0], ca_d_ff[1], ca_d_ff[2], ca_d_ff[3], neg_d_ff};

   crgm_div #(
      .LANES (4),
      .DEN_W (POS_W),
      .Q_W   (MAG_W),
      .TAG_W (TAG2_W)
   ) u_div_blend (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (ctl2),
      .den_in  (span_d_ff),
      .rem_in  ('0),
      .dvd_in  (mag_d_ff),
      .tag_in  (tag2_in),
      .vld_out (v2),
      .q_out   (q2),
      .tag_out (tag2)
   );

   // ---------------------------------------------------------------- stage E: output
   logic                    e_grey, e_use;
   logic [CB-1:0]           e_gval;
   logic [3:0]              e_neg;
   logic [CB-1:0]           e_ca  [4];
   logic [CB-1:0]           e_out [4];
   logic signed [PRD_W-1:0] e_sum [4];
   logic [CB-1:0]           red_ff, green_ff, blue_ff, alpha_ff;

   always_comb begin
      e_grey = tag2[TAG2_W-1];
      e_use  = tag2[TAG2_W-2];
      e_gval = tag2[TAG2_W-3 -: CB];
      e_neg  = tag2[3:0];
      for (int c = 0; c < 4; c++) begin
         e_ca[c]  = tag2[4 + (3-c)*CB +: CB];
         e_sum[c] = e_neg[c]
                  ? $signed(PRD_W'(e_ca[c])) - $signed(PRD_W'(q2[c]))
                  : $signed(PRD_W'(e_ca[c])) + $signed(PRD_W'(q2[c]));
         if (!e_use) begin
            e_out[c] = e_ca[c];
         end else if (e_sum[c] < 0) begin
            e_out[c] = '0;
         end else if (e_sum[c] > $signed(PRD_W'(CH_MAX))) begin
            e_out[c] = CH_MAX;
         end else begin
            e_out[c] = e_sum[c][CB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v2;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         red_ff   <= e_grey ? e_gval : e_out[0];
         green_ff <= e_grey ? e_gval : e_out[1];
         blue_ff  <= e_grey ? e_gval : e_out[2];
         alpha_ff <= e_grey ? CH_MAX : e_out[3];
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.red   = red_ff;
   assign rsp_bus.green = green_ff;
   assign rsp_bus.blue  = blue_ff;
   assign rsp_bus.alpha = alpha_ff;

   // ---------------------------------------------------------------- checks
   `CRGM_ASSERT_NOW(a_stall_blocks_req, rsp_bus.valid && !rsp_bus.ready, !req_bus.ready, "input taken during output stall")
   `CRGM_ASSERT_NOW(a_t_in_range, va_ff, t_ff <= T_ONE, "t above one")
   `CRGM_ASSERT_NEXT(a_pipe_to_out, adv && v2, rsp_bus.valid, "finished beat not presented")
endmodule
